// File: hdl/blkml_pkg.sv
// Shared constants, types and interpolation helper of the kick map lookup unit.
package blkml_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int MAP_ENTRIES = 4096;
	localparam int ADDR_W      = $clog2(MAP_ENTRIES);
	localparam int DIM_W       = 13;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [2:0] REG_X_ORIGIN = 3'd0;
	localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
	localparam logic [2:0] REG_INV_X    = 3'd2;
	localparam logic [2:0] REG_INV_Y    = 3'd3;
	localparam logic [2:0] REG_COLUMNS  = 3'd4;
	localparam logic [2:0] REG_ROWS     = 3'd5;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	typedef struct packed {
		logic signed [31:0] x_origin;
		logic signed [31:0] y_origin;
		logic [31:0]        inv_x;
		logic [31:0]        inv_y;
		logic [DIM_W-1:0]   columns;
		logic [DIM_W-1:0]   rows;
	} cfg_t;

	typedef struct packed {
		logic                 lookup;
		logic                 ok;
		logic [ADDR_W-1:0]    idx;
		logic signed [31:0]   lkx;
		logic signed [31:0]   lky;
		logic [ADDR_W-1:0]    ix;
		logic [ADDR_W-1:0]    iy;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
	} qent_t;

	// (1-f)*a + f*b, rounded half up and saturated to 32 bits.
	function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic [FRAC_BITS-1:0] f);
		logic signed [FRAC_BITS+1:0] wa;
		logic signed [FRAC_BITS+1:0] wb;
		logic signed [FRAC_BITS+34:0] s;
		logic signed [34:0] r;
		wa = $signed((FRAC_BITS+2)'(1 << FRAC_BITS) - (FRAC_BITS+2)'(f));
		wb = $signed((FRAC_BITS+2)'(f));
		s = (FRAC_BITS+35)'(a) * (FRAC_BITS+35)'(wa) + (FRAC_BITS+35)'(b) * (FRAC_BITS+35)'(wb)
			+ (FRAC_BITS+35)'(1 << (FRAC_BITS-1));
		r = 35'(s >>> FRAC_BITS);
		if (r > 35'sd2147483647)
			lerp = 32'sh7FFFFFFF;
		else if (r < -35'sd2147483648)
			lerp = 32'sh80000000;
		else
			lerp = r[31:0];
	endfunction

endpackage

// File: hdl/blkml_front.sv
// Front end: takes items, locates the grid cell and classifies lookups.
module blkml_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 func,
	input  logic [11:0]          entry_index,
	input  logic signed [31:0]   load_kick_x,
	input  logic signed [31:0]   load_kick_y,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  blkml_pkg::cfg_t      cfg,
	output logic                 push,
	output blkml_pkg::qent_t     push_ent
);
	import blkml_pkg::*;

	logic                v_s1, v_s2;
	logic                func_s1, func_s2;
	logic [11:0]         idx_s1, idx_s2;
	logic signed [31:0]  lkx_s1, lky_s1, lkx_s2, lky_s2;
	logic signed [32:0]  dx_s1, dy_s1;
	logic                negx_s2, negy_s2;
	logic [63:0]         px_s2, py_s2;
	logic                bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= func;
		idx_s1  <= entry_index;
		lkx_s1  <= load_kick_x;
		lky_s1  <= load_kick_y;
		dx_s1   <= {pos_x[31], pos_x} - {cfg.x_origin[31], cfg.x_origin};
		dy_s1   <= {pos_y[31], pos_y} - {cfg.y_origin[31], cfg.y_origin};
		func_s2 <= func_s1;
		idx_s2  <= idx_s1;
		lkx_s2  <= lkx_s1;
		lky_s2  <= lky_s1;
		negx_s2 <= dx_s1[32] && (cfg.inv_x != 32'd0);
		negy_s2 <= dy_s1[32] && (cfg.inv_y != 32'd0);
		px_s2   <= dx_s1[32] ? 64'd0 : dx_s1[31:0] * cfg.inv_x;
		py_s2   <= dy_s1[32] ? 64'd0 : dy_s1[31:0] * cfg.inv_y;
	end

	// The last column and row only bound cells, so they never start one.
	always_comb begin
		bad = (cfg.columns < DIM_W'(2)) || (cfg.rows < DIM_W'(2)) || negx_s2 || negy_s2
			|| (px_s2[63:32] > ({19'd0, cfg.columns} - 32'd2))
			|| (py_s2[63:32] > ({19'd0, cfg.rows} - 32'd2));
	end

	assign push = v_s2;
	always_comb begin
		push_ent.lookup = func_s2;
		push_ent.ok     = !bad;
		push_ent.idx    = idx_s2;
		push_ent.lkx    = lkx_s2;
		push_ent.lky    = lky_s2;
		push_ent.ix     = px_s2[32+ADDR_W-1:32];
		push_ent.iy     = py_s2[32+ADDR_W-1:32];
		push_ent.fx     = px_s2[2*FRAC_BITS-1:FRAC_BITS];
		push_ent.fy     = py_s2[2*FRAC_BITS-1:FRAC_BITS];
	end

endmodule

// File: hdl/blkml_queue.sv
// Short item queue between the front end and the back end.
module blkml_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  blkml_pkg::qent_t push_ent,
	input  logic             pop,
	output blkml_pkg::qent_t pop_ent,
	output logic             empty,
	output logic             full
);
	import blkml_pkg::*;

	qent_t             slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_ent = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_ent;
	end

	assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("item pushed into a full queue");
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("item popped from an empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
			(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count lost a push");

endmodule

// File: hdl/blkml_back.sv
// Back end: table storage, four-entry fetch and bilinear interpolation.
module blkml_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop,
	input  blkml_pkg::qent_t    pop_ent,
	input  blkml_pkg::cfg_t     cfg,
	output logic                done,
	output logic signed [31:0]  kick_x,
	output logic signed [31:0]  kick_y,
	output logic                in_map
);
	import blkml_pkg::*;

	// Two copies of the table pair so that four entries come out per cycle.
	logic [63:0] mem_a [MAP_ENTRIES];
	logic [63:0] mem_b [MAP_ENTRIES];

	logic              v_b1, v_b2, v_b3, v_b4, v_b5;
	qent_t             ent_b1;
	logic [25:0]       e00, e11;
	logic              lk_b2, lk_b3;
	logic              ok_b2, ok_b3, ok_b4, ok_b5;
	logic [ADDR_W-1:0] idx_b2, a00_b2, a10_b2, a01_b2, a11_b2;
	logic [63:0]       wd_b2;
	logic [FRAC_BITS-1:0] fx_b2, fy_b2, fx_b3, fy_b3, fx_b4;
	logic [63:0]       r00_b3, r10_b3, r01_b3, r11_b3;
	logic signed [31:0] lx0_b4, lx1_b4, ly0_b4, ly1_b4;
	logic signed [31:0] kx_b5, ky_b5;

	always_comb begin
		e00 = 26'(ent_b1.ix) + 26'(ent_b1.iy) * 26'(cfg.columns);
		e11 = e00 + 26'(cfg.columns) + 26'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
			v_b5 <= 1'b0;
		end else begin
			v_b1 <= pop;
			v_b2 <= v_b1;
			v_b3 <= v_b2 && lk_b2;
			v_b4 <= v_b3;
			v_b5 <= v_b4;
		end
	end

	always_ff @(posedge clk) begin
		ent_b1 <= pop_ent;
		lk_b2  <= ent_b1.lookup == FUNC_LOOKUP;
		ok_b2  <= ent_b1.ok && (e11 < 26'(MAP_ENTRIES));
		idx_b2 <= ent_b1.idx;
		wd_b2  <= {ent_b1.lkx, ent_b1.lky};
		a00_b2 <= e00[ADDR_W-1:0];
		a10_b2 <= ADDR_W'(e00 + 26'd1);
		a01_b2 <= ADDR_W'(e11 - 26'd1);
		a11_b2 <= e11[ADDR_W-1:0];
		fx_b2  <= ent_b1.fx;
		fy_b2  <= ent_b1.fy;
		lk_b3  <= lk_b2;
		ok_b3  <= ok_b2;
		fx_b3  <= fx_b2;
		fy_b3  <= fy_b2;
		ok_b4  <= ok_b3;
		fx_b4  <= fx_b3;
		lx0_b4 <= lerp(r00_b3[63:32], r01_b3[63:32], fy_b3);
		lx1_b4 <= lerp(r10_b3[63:32], r11_b3[63:32], fy_b3);
		ly0_b4 <= lerp(r00_b3[31:0], r01_b3[31:0], fy_b3);
		ly1_b4 <= lerp(r10_b3[31:0], r11_b3[31:0], fy_b3);
		ok_b5  <= ok_b4;
		kx_b5  <= ok_b4 ? lerp(lx0_b4, lx1_b4, fx_b4) : 32'sd0;
		ky_b5  <= ok_b4 ? lerp(ly0_b4, ly1_b4, fx_b4) : 32'sd0;
	end

	always_ff @(posedge clk) begin
		if (v_b2 && !lk_b2) begin
			mem_a[idx_b2] <= wd_b2;
			mem_b[idx_b2] <= wd_b2;
		end
		r00_b3 <= mem_a[a00_b2];
		r10_b3 <= mem_a[a10_b2];
		r01_b3 <= mem_b[a01_b2];
		r11_b3 <= mem_b[a11_b2];
	end

	assign done   = v_b5;
	assign kick_x = kx_b5;
	assign kick_y = ky_b5;
	assign in_map = ok_b5;

	assert property (@(posedge clk) disable iff (!arst_n) v_b3 |-> lk_b3)
		else $error("load item reached the interpolation stage");
	assert property (@(posedge clk) disable iff (!arst_n) v_b5 |-> $past(v_b2 && lk_b2, 3))
		else $error("result without a lookup item three stages earlier");
	assert property (@(posedge clk) disable iff (!arst_n)
			(v_b5 && !ok_b5) |-> (kx_b5 == 32'sd0 && ky_b5 == 32'sd0))
		else $error("nonzero kick for a position outside the grid");

endmodule

// File: hdl/bilinear_kick_map_lookup_unit.sv
// Top level of the bilinear kick map lookup unit.
// Usage: an item is taken at a rising edge where start is high and busy low.
// func selects a load (entry_index, load_kick_x/y written into both tables,
// no result) or a lookup (pos_x/pos_y). A lookup returns kick_x, kick_y and
// in_map, marked by done for exactly one cycle. One item is taken every
// cycle; the rate is set by the four-entry fetch, served by two table copies
// with two read ports each.
// The front end registers the position offset and the 32x32 cell product,
// the queue decouples it from the back end, which computes the entry address,
// reads the tables and interpolates along y then x.
// The receiver cannot stall: done is a strobe and the back end drains the
// queue every cycle, so busy stays low in operation.
// Reset clears the pipeline and restores the configuration registers; the
// tables are not cleared and must be loaded before lookups use them.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written only while idle; the block itself does not enforce this.
module bilinear_kick_map_lookup_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                func,
	input  logic [11:0]         entry_index,
	input  logic signed [31:0]  load_kick_x,
	input  logic signed [31:0]  load_kick_y,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	output logic                done,
	output logic signed [31:0]  kick_x,
	output logic signed [31:0]  kick_y,
	output logic                in_map
);
	import blkml_pkg::*;

	cfg_t  cfg_q;
	logic  accept, push, pop, empty, full;
	qent_t push_ent, pop_ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_origin <= 32'sd0;
			cfg_q.y_origin <= 32'sd0;
			cfg_q.inv_x    <= 32'd65536;
			cfg_q.inv_y    <= 32'd65536;
			cfg_q.columns  <= DIM_W'(64);
			cfg_q.rows     <= DIM_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_X_ORIGIN: cfg_q.x_origin <= cfg_wdata;
				REG_Y_ORIGIN: cfg_q.y_origin <= cfg_wdata;
				REG_INV_X:    cfg_q.inv_x    <= cfg_wdata;
				REG_INV_Y:    cfg_q.inv_y    <= cfg_wdata;
				REG_COLUMNS:  cfg_q.columns  <= cfg_wdata[DIM_W-1:0];
				REG_ROWS:     cfg_q.rows     <= cfg_wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy   = full;
	assign accept = start && !busy;
	assign pop    = !empty;

	blkml_front u_front (
		.clk, .arst_n, .accept, .func, .entry_index, .load_kick_x, .load_kick_y,
		.pos_x, .pos_y, .cfg(cfg_q), .push, .push_ent
	);

	blkml_queue u_queue (
		.clk, .arst_n, .push, .push_ent, .pop, .pop_ent, .empty, .full
	);

	blkml_back u_back (
		.clk, .arst_n, .pop, .pop_ent, .cfg(cfg_q), .done, .kick_x, .kick_y, .in_map
	);

	assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("queue filled although the back end drains every cycle");
	assert property (@(posedge clk) disable iff (!arst_n)
			done |-> $past(start && !busy && func == FUNC_LOOKUP, 8))
		else $error("result without a lookup item eight cycles earlier");
	assert property (@(posedge clk) disable iff (!arst_n)
			(done && !in_map) |-> (kick_x == 32'sd0 && kick_y == 32'sd0))
		else $error("nonzero kick reported outside the grid");

endmodule

// File: verif/testbench.sv
// Self-checking testbench of the bilinear kick map lookup unit with its own lookup predictor.
module testbench;
	import blkml_pkg::*;

	typedef struct packed {
		logic signed [31:0] kx;
		logic signed [31:0] ky;
		logic               hit;
	} kick_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               func;
	logic [11:0]        entry_index;
	logic signed [31:0] load_kick_x;
	logic signed [31:0] load_kick_y;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_wdata;
	logic               done;
	logic signed [31:0] kick_x;
	logic signed [31:0] kick_y;
	logic               in_map;

	bilinear_kick_map_lookup_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.entry_index(entry_index), .load_kick_x(load_kick_x), .load_kick_y(load_kick_y),
		.pos_x(pos_x), .pos_y(pos_y), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .done(done), .kick_x(kick_x), .kick_y(kick_y),
		.in_map(in_map)
	);

	// Shadow copies of the grid registers and of both tables.
	longint          x_org, y_org;
	longint unsigned inv_x, inv_y, n_cols, n_rows;
	logic signed [31:0] kx_mem [MAP_ENTRIES];
	logic signed [31:0] ky_mem [MAP_ENTRIES];
	bit                 loaded [MAP_ENTRIES];

	kick_t  expected_kicks[$];
	int     failures;
	int     gap_pct;
	int     quiet_cycles;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic longint sat_q(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint blend(input longint a, input longint b, input longint f);
		longint s;
		s = a * (65536 - f) + b * f + 32768;
		return sat_q(s >>> FRAC_BITS);
	endfunction

	// Finds the lower-left entry of the cell holding the position; 0 if off the map.
	function automatic bit find_cell(input logic signed [31:0] px, input logic signed [31:0] py,
			output longint unsigned e00, output longint fx, output longint fy);
		longint          dx, dy;
		bit [63:0]       p;
		longint unsigned ix, iy;
		e00 = 0;
		fx = 0;
		fy = 0;
		if (n_cols < 2 || n_rows < 2)
			return 0;
		dx = longint'(px) - x_org;
		dy = longint'(py) - y_org;
		if ((dx < 0 && inv_x != 0) || (dy < 0 && inv_y != 0))
			return 0;
		p = (dx < 0) ? 64'd0 : 64'(dx) * 64'(inv_x);
		ix = p[63:32];
		fx = p[31:16];
		p = (dy < 0) ? 64'd0 : 64'(dy) * 64'(inv_y);
		iy = p[63:32];
		fy = p[31:16];
		if (ix > n_cols - 2 || iy > n_rows - 2)
			return 0;
		e00 = ix + iy * n_cols;
		if (e00 + n_cols + 1 >= MAP_ENTRIES)
			return 0;
		return 1;
	endfunction

	function automatic kick_t predict_kick(input logic signed [31:0] px,
			input logic signed [31:0] py);
		kick_t           r;
		longint unsigned e;
		longint          fx, fy, left, right;
		r = '0;
		if (!find_cell(px, py, e, fx, fy))
			return r;
		left = blend(kx_mem[e], kx_mem[e + n_cols], fy);
		right = blend(kx_mem[e + 1], kx_mem[e + n_cols + 1], fy);
		r.kx = 32'(blend(left, right, fx));
		left = blend(ky_mem[e], ky_mem[e + n_cols], fy);
		right = blend(ky_mem[e + 1], ky_mem[e + n_cols + 1], fy);
		r.ky = 32'(blend(left, right, fx));
		r.hit = 1'b1;
		return r;
	endfunction

	// Drives one item at the falling edge and holds it until the block takes it.
	task automatic send_item(input logic f, input logic [11:0] idx, input logic [31:0] lx,
			input logic [31:0] ly, input logic [31:0] px, input logic [31:0] py);
		if ($urandom_range(99) < gap_pct)
			repeat ($urandom_range(1, 3)) @(negedge clk);
		func = f;
		entry_index = idx;
		load_kick_x = lx;
		load_kick_y = ly;
		pos_x = px;
		pos_y = py;
		start = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (f == FUNC_LOAD) begin
			kx_mem[idx] = lx;
			ky_mem[idx] = ly;
			loaded[idx] = 1'b1;
		end else begin
			expected_kicks.push_back(predict_kick(px, py));
		end
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic load_entry(input logic [11:0] idx);
		send_item(FUNC_LOAD, idx, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Any never-loaded corner of the target cell is loaded first.
	task automatic look_up(input logic [31:0] px, input logic [31:0] py);
		longint unsigned e;
		longint          fx, fy;
		if (find_cell(px, py, e, fx, fy)) begin
			if (!loaded[e]) load_entry(12'(e));
			if (!loaded[e + 1]) load_entry(12'(e + 1));
			if (!loaded[e + n_cols]) load_entry(12'(e + n_cols));
			if (!loaded[e + n_cols + 1]) load_entry(12'(e + n_cols + 1));
		end
		send_item(FUNC_LOOKUP, 12'($urandom), $urandom, $urandom, px, py);
	endtask

	task automatic drain();
		while (expected_kicks.size() != 0)
			@(negedge clk);
	endtask

	// Loads never return a result, so the pipeline depth is waited out too.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		drain();
		repeat (12) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_X_ORIGIN: x_org = longint'($signed(val));
			REG_Y_ORIGIN: y_org = longint'($signed(val));
			REG_INV_X:    inv_x = val;
			REG_INV_Y:    inv_y = val;
			REG_COLUMNS:  n_cols = val[DIM_W-1:0];
			REG_ROWS:     n_rows = val[DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_grid(input logic [31:0] xo, input logic [31:0] yo,
			input logic [31:0] ivx, input logic [31:0] ivy,
			input logic [31:0] cols, input logic [31:0] rows);
		write_reg(REG_X_ORIGIN, xo);
		write_reg(REG_Y_ORIGIN, yo);
		write_reg(REG_INV_X, ivx);
		write_reg(REG_INV_Y, ivy);
		write_reg(REG_COLUMNS, cols);
		write_reg(REG_ROWS, rows);
	endtask

	task automatic test_reset_grid();
		load_entry(12'd0);
		send_item(FUNC_LOAD, 12'd1, 32'h7FFFFFFF, 32'h80000000, '0, '0);
		send_item(FUNC_LOAD, 12'd64, 32'h80000000, 32'h7FFFFFFF, '0, '0);
		send_item(FUNC_LOAD, 12'd65, 32'h7FFFFFFF, 32'h7FFFFFFF, '0, '0);
		look_up(32'h0000_0000, 32'h0000_0000);
		look_up(32'h0000_8000, 32'h0000_8000);
		look_up(32'h0000_FFFF, 32'h0000_0001);
		look_up(32'h003E_FFFF, 32'h003E_FFFF);
		look_up(32'h003F_0000, 32'h0001_0000);
		look_up(32'hFFFF_FFFF, 32'h0000_0000);
		look_up(32'h7FFF_FFFF, 32'h8000_0000);
		load_entry(12'hFFF);
	endtask

	task automatic test_grid_extremes();
		// A zero step puts every position in cell 0 along that axis.
		set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd2, 32'd2);
		look_up(32'h8000_0000, 32'h8000_0000);
		look_up(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		// Fewer than two points along an axis leaves no cell at all.
		write_reg(REG_COLUMNS, 32'd1);
		look_up(32'h0, 32'h0);
		write_reg(REG_COLUMNS, 32'd0);
		look_up(32'h0, 32'h0);
		// A grid wider than the tables only keeps the cells that fit.
		set_grid(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd4096, 32'd2);
		look_up(32'h0, 32'h0);
		set_grid(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_F800, 32'd2);
		look_up(32'h07FE_0000, 32'h0000_C000);
		look_up(32'h07FE_FFFF, 32'h0);
		look_up(32'h0, 32'h0001_0000);
		set_grid(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd8191, 32'd8191);
		look_up(32'hFFFF_0000, 32'hFFFF_8000);
		look_up(32'h7FFF_FFFF, 32'h0);
	endtask

	task automatic random_grid();
		int     sel;
		sel = $urandom_range(9);
		set_grid(
			(sel < 7) ? 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000)
				: $urandom,
			(sel < 7) ? 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000)
				: $urandom,
			(sel == 0) ? 32'd0 : (sel < 6) ? (32'h0001_0000 << $urandom_range(0, 4))
				: $urandom_range(32'h0000_4000, 32'hFFFF_FFFF),
			(sel == 9) ? 32'd0 : (sel < 6) ? (32'h0001_0000 << $urandom_range(0, 4))
				: $urandom_range(32'h0000_4000, 32'hFFFF_FFFF),
			(sel == 8) ? 32'd2048 : $urandom_range(2, 7),
			(sel == 1) ? $urandom_range(0, 1) : $urandom_range(2, 6));
		if (n_cols * n_rows <= 64)
			for (int e = 0; e < n_cols * n_rows; e++)
				load_entry(12'(e));
	endtask

	task automatic random_lookups(input int count);
		longint spx, spy;
		spx = (inv_x == 0) ? 64'sd1 << 20 : (longint'(n_cols) << 32) / longint'(inv_x);
		spy = (inv_y == 0) ? 64'sd1 << 20 : (longint'(n_rows) << 32) / longint'(inv_y);
		if (spx > 64'sd1 << 30) spx = 64'sd1 << 30;
		if (spy > 64'sd1 << 30) spy = 64'sd1 << 30;
		repeat (count) begin
			if ($urandom_range(9) == 0)
				look_up($urandom, $urandom);
			else if ($urandom_range(9) == 0)
				load_entry(12'($urandom));
			else
				look_up(32'(sat_q(x_org + $urandom_range(0, 32'(spx * 5 / 4)) - spx / 8)),
					32'(sat_q(y_org + $urandom_range(0, 32'(spy * 5 / 4)) - spy / 8)));
		end
	endtask

	task automatic test_random_traffic(input int pct);
		gap_pct = pct;
		repeat (4) begin
			random_grid();
			random_lookups(45);
		end
	endtask

	task automatic test_paused_sender();
		random_lookups(10);
		drain();
		random_lookups(10);
	endtask

	// Results arrive as strobes and are checked against the oldest prediction.
	always @(posedge clk) begin
		kick_t want;
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 5000) begin
				$display("bilinear_kick_map_lookup_unit verification failed");
				$finish;
			end
			if (done) begin
				if (expected_kicks.size() == 0) begin
					$error("result with no lookup outstanding");
					failures++;
				end else begin
					want = expected_kicks.pop_front();
					if (kick_x !== want.kx) begin
						$error("kick_x expected %h got %h", want.kx, kick_x);
						failures++;
					end
					if (kick_y !== want.ky) begin
						$error("kick_y expected %h got %h", want.ky, kick_y);
						failures++;
					end
					if (in_map !== want.hit) begin
						$error("in_map expected %b got %b", want.hit, in_map);
						failures++;
					end
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_LOAD;
		entry_index = '0;
		load_kick_x = '0;
		load_kick_y = '0;
		pos_x = '0;
		pos_y = '0;
		cfg_we = 1'b0;
		cfg_index = REG_X_ORIGIN;
		cfg_wdata = '0;
		failures = 0;
		quiet_cycles = 0;
		gap_pct = 0;
		x_org = 0;
		y_org = 0;
		inv_x = 65536;
		inv_y = 65536;
		n_cols = 64;
		n_rows = 64;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_grid();
		test_grid_extremes();
		test_random_traffic(14);
		test_paused_sender();
		test_random_traffic(50);
		gap_pct = 0;
		test_random_traffic(0);
		drain();
		repeat (20) @(negedge clk);
		if (failures == 0 && expected_kicks.size() == 0)
			$display("bilinear_kick_map_lookup_unit verification clean");
		else
			$display("bilinear_kick_map_lookup_unit verification failed");
		$finish;
	end

endmodule

// File: sim.f
hdl/blkml_pkg.sv
hdl/blkml_front.sv
hdl/blkml_queue.sv
hdl/blkml_back.sv
hdl/bilinear_kick_map_lookup_unit.sv
verif/testbench.sv
